@@ src/bse_pkg.sv @@
// Shared constants, field types and RAM request struct for the stack engine.
package bse_pkg;

    localparam int DEPTH = 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef logic        [2:0]    t_op;
    typedef logic signed [31:0]   t_word;
    typedef logic        [7:0]    t_count;
    typedef logic        [2:0]    t_status;
    typedef logic        [AW-1:0] t_addr;
    typedef logic        [CW-1:0] t_fill;

    localparam t_op OP_PUSH    = 3'd0;
    localparam t_op OP_POP     = 3'd1;
    localparam t_op OP_SEARCH  = 3'd2;
    localparam t_op OP_PEEK    = 3'd3;
    localparam t_op OP_REVERSE = 3'd4;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

endpackage

@@ src/bse_if.sv @@
// Request and response channel interfaces of the stack engine.
interface bse_req_if;
    import bse_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_word  value;
    t_count position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface bse_rsp_if;
    import bse_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   data;
    t_count  found_position;
    t_count  count;

    modport source (output valid, output status, output data, output found_position,
                    output count, input ready);
    modport sink   (input valid, input status, input data, input found_position,
                    input count, output ready);
endinterface

@@ src/bse_ram.sv @@
// Entry storage: one write port, two registered read ports.
module bse_ram (
    input  logic              i_clk,
    input  bse_pkg::t_ram_req i_req,
    output bse_pkg::t_word    o_rdata_a,
    output bse_pkg::t_word    o_rdata_b
);
    import bse_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata_a;
    t_word r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ src/bounded_stack_engine_unit.sv @@
// Bounded LIFO stack engine: sequencer around the entry RAM.
//
// Requests arrive on i_req (operation, value, position) and each one yields
// exactly one beat on o_rsp (status, data, found_position, count). One
// request is worked at a time; i_req.ready is high only while the sequencer
// is idle.
// Steps from accept to result in the output register:
//   push, unknown code, any rejected request: execute, then finish
//   pop, peek: execute with the RAM read, S_READ, then finish
//   search: one entry compared per cycle from the bottom up to a hit, then finish
//   reverse: S_REV_WA and S_REV_WB per swapped pair, two reads and two writes a pair
// The RAM has one write port, so each swap writes its two entries in turn.
// A result sits in the output register until o_rsp.ready takes it; the next
// request may be accepted and worked meanwhile, but its result waits in the
// finish state while the register is still full.
// Reset clears the fill count and the handshake state; the RAM is not
// cleared, since no entry at or above the fill count ever reaches a result.
module bounded_stack_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bse_req_if.sink     i_req,
    bse_rsp_if.source   o_rsp
);
    import bse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SRCH,
        S_REV_WA,
        S_REV_WB,
        S_FIN
    } t_state;

    t_state  r_state;
    t_fill   r_cnt;
    t_op     r_op;
    t_word   r_val;
    t_count  r_pos;
    t_status r_res_status;
    t_word   r_res_data;
    t_count  r_res_found;
    t_fill   r_idx;
    logic    r_chk;
    t_fill   r_chk_idx;
    t_addr   r_lo;
    t_addr   r_hi;
    t_word   r_tmp;
    logic    r_ovalid;
    t_status r_ostatus;
    t_word   r_odata;
    t_count  r_ofound;
    t_count  r_ocount;

    t_ram_req ram_req;
    t_word    rdata_a;
    t_word    rdata_b;

    logic   is_empty;
    logic   is_full;
    t_count cnt_ext;
    t_addr  top_addr;
    t_addr  peek_addr;
    t_addr  lo_next;
    t_addr  hi_next;
    logic   srch_hit;
    logic   srch_last;
    logic   idx_in;

    assign cnt_ext   = t_count'(r_cnt);
    assign is_empty  = (r_cnt == '0);
    assign is_full   = (r_cnt == t_fill'(DEPTH));
    assign top_addr  = t_addr'(r_cnt - 1'b1);
    assign peek_addr = t_addr'(cnt_ext - r_pos);
    assign lo_next   = t_addr'(r_lo + 1'b1);
    assign hi_next   = t_addr'(r_hi - 1'b1);
    assign srch_hit  = r_chk && (rdata_a == r_val);
    assign srch_last = r_chk && (r_chk_idx == t_fill'(r_cnt - 1'b1));
    assign idx_in    = (r_idx < r_cnt);

    bse_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        ram_req = '{we: 1'b0, waddr: '0, wdata: r_val, raddr_a: '0, raddr_b: '0};
        unique case (r_state)
            S_EXEC: begin
                if (r_op == OP_PUSH && !is_full) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = t_addr'(r_cnt);
                end
                if (r_op == OP_POP) begin
                    ram_req.raddr_a = top_addr;
                end else if (r_op == OP_PEEK) begin
                    ram_req.raddr_a = peek_addr;
                end else if (r_op == OP_REVERSE) begin
                    ram_req.raddr_a = '0;
                    ram_req.raddr_b = top_addr;
                end
            end
            S_SRCH: begin
                if (idx_in) begin
                    ram_req.raddr_a = t_addr'(r_idx);
                end
            end
            S_REV_WA: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_lo;
                ram_req.wdata = rdata_b;
            end
            S_REV_WB: begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = r_hi;
                ram_req.wdata   = r_tmp;
                ram_req.raddr_a = lo_next;
                ram_req.raddr_b = hi_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_chk    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output beat once taken; the finish state reloads it itself
            if (r_ovalid && o_rsp.ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op         <= i_req.operation;
                        r_val        <= i_req.value;
                        r_pos        <= i_req.position;
                        r_res_status <= ST_OK;
                        r_res_data   <= '0;
                        r_res_found  <= '0;
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_PUSH) begin
                        r_state <= S_FIN;
                        if (is_full) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_cnt <= t_fill'(r_cnt + 1'b1);
                        end
                    end else if (r_op == OP_POP || r_op == OP_SEARCH
                                 || r_op == OP_PEEK || r_op == OP_REVERSE) begin
                        if (is_empty) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_FIN;
                        end else if (r_op == OP_POP) begin
                            r_cnt   <= t_fill'(r_cnt - 1'b1);
                            r_state <= S_READ;
                        end else if (r_op == OP_PEEK) begin
                            if (r_pos == '0 || r_pos > cnt_ext) begin
                                r_res_status <= ST_BAD_POS;
                                r_state      <= S_FIN;
                            end else begin
                                r_state <= S_READ;
                            end
                        end else if (r_op == OP_SEARCH) begin
                            r_res_status <= ST_NOT_FOUND;
                            r_idx        <= '0;
                            r_chk        <= 1'b0;
                            r_state      <= S_SRCH;
                        end else if (r_cnt != t_fill'(1)) begin
                            r_lo    <= '0;
                            r_hi    <= top_addr;
                            r_state <= S_REV_WA;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_READ: begin
                    r_res_data <= rdata_a;
                    r_state    <= S_FIN;
                end
                S_SRCH: begin
                    if (srch_hit) begin
                        r_res_status <= ST_OK;
                        r_res_found  <= t_count'(cnt_ext - t_count'(r_chk_idx));
                        r_chk        <= 1'b0;
                        r_state      <= S_FIN;
                    end else if (srch_last) begin
                        r_chk   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        // compare next cycle what is read now
                        r_chk     <= idx_in;
                        r_chk_idx <= r_idx;
                        if (idx_in) begin
                            r_idx <= t_fill'(r_idx + 1'b1);
                        end
                    end
                end
                S_REV_WA: begin
                    r_tmp   <= rdata_a;
                    r_state <= S_REV_WB;
                end
                S_REV_WB: begin
                    if (lo_next < hi_next) begin
                        r_lo    <= lo_next;
                        r_hi    <= hi_next;
                        r_state <= S_REV_WA;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold the result while the output register is still full
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_odata   <= r_res_data;
                        r_ofound  <= r_res_found;
                        r_ocount  <= cnt_ext;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_ostatus;
    assign o_rsp.data           = r_odata;
    assign o_rsp.found_position = r_ofound;
    assign o_rsp.count          = r_ocount;

endmodule

@@ verif/bounded_stack_engine_unit_test.sv @@
// Self-checking test of the bounded stack engine: directed table, then random requests.
module bounded_stack_engine_unit_test;
    import bse_pkg::*;

    localparam int   RANDOM_ITEMS    = 450;
    localparam int   HOLD_OFF_CYCLES = 120;
    localparam int   STALL_LIMIT     = 1000;
    localparam int   SHOWN_ERRORS    = 10;
    localparam t_op  OP_SPARE_FIRST  = 3'd5;
    localparam t_op  OP_SPARE_LAST   = 3'd7;
    localparam t_word WORD_MIN       = 32'sh8000_0000;
    localparam t_word WORD_MAX       = 32'sh7fff_ffff;

    typedef struct packed {
        t_status status;
        t_word   data;
        t_count  found_pos;
        t_count  count;
    } t_stack_result;

    typedef struct {
        t_op           op;
        t_word         value;
        t_count        position;
        bit            typed;
        t_stack_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bse_req_if req_bus ();
    bse_rsp_if rsp_bus ();

    bounded_stack_engine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_word         stack_mem [DEPTH];
    int            stack_fill = 0;
    t_stack_result awaited_results [$];
    t_dir_row      dir_rows [$];
    int            error_count      = 0;
    int            stall_cycles     = 0;
    int            idle_pct         = 10;
    bit            hold_off_pending = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow stack and return the result it must produce.
    function automatic t_stack_result apply_stack_op(t_op op, t_word val, t_count pos);
        t_stack_result r;
        t_word         tmp;
        int            lo;
        int            hi;
        int            i;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        case (op)
            OP_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[stack_fill] = val;
                    stack_fill++;
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    r.data = stack_mem[stack_fill];
                end
            end
            OP_SEARCH: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOT_FOUND;
                    // scan from the bottom, report the lowest match
                    for (i = 0; i < stack_fill; i++) begin
                        if (!hit && stack_mem[i] == val) begin
                            hit         = 1'b1;
                            r.status    = ST_OK;
                            r.found_pos = t_count'(stack_fill - i);
                        end
                    end
                end
            end
            OP_PEEK: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos == 0 || int'(pos) > stack_fill) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.data = stack_mem[stack_fill - int'(pos)];
                end
            end
            OP_REVERSE: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    lo = 0;
                    hi = stack_fill - 1;
                    while (lo < hi) begin
                        tmp           = stack_mem[lo];
                        stack_mem[lo] = stack_mem[hi];
                        stack_mem[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;
        endcase
        r.count = t_count'(stack_fill);
        return r;
    endfunction

    function automatic t_dir_row row(t_op op, t_word val, t_count pos, bit typed,
                                     t_status st, t_word dat, t_count fp, t_count cnt);
        t_dir_row d;
        d.op        = op;
        d.value     = val;
        d.position  = pos;
        d.typed     = typed;
        d.want      = '{status: st, data: dat, found_pos: fp, count: cnt};
        return d;
    endfunction

    function automatic void note_failure(string what, t_stack_result want);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $write("ERROR %0s: expected st=%0d data=%0d pos=%0d cnt=%0d, ",
                   what, want.status, want.data, want.found_pos, want.count);
            $display("got st=%0d data=%0d pos=%0d cnt=%0d",
                     rsp_bus.status, rsp_bus.data, rsp_bus.found_position, rsp_bus.count);
        end
    endfunction

    // Hold the beat until the engine takes it; optionally idle first.
    task automatic send_request(t_op op, t_word val, t_count pos);
        while ($urandom_range(99) < idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.value     <= val;
        req_bus.position  <= pos;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
    endtask

    initial begin : drive_ready
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_stack_result want;
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
                note_failure("unexpected result", '0);
            end else begin
                want = awaited_results.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.data !== want.data ||
                    rsp_bus.found_position !== want.found_pos || rsp_bus.count !== want.count)
                    note_failure("result mismatch", want);
            end
        end
    end

    initial begin : drive_requests
        t_dir_row      d;
        t_stack_result pred;
        t_op           op;
        t_word         val;
        t_count        pos;
        int            n;
        int            roll;
        int            push_pct;
        int            pop_pct;

        foreach (stack_mem[k])
            stack_mem[k] = '0;
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= OP_PUSH;
        req_bus.value     <= '0;
        req_bus.position  <= '0;

        // empty stack, unused codes, fill to the top, full, bad positions, hits and misses
        dir_rows.push_back(row(OP_POP,         0, 0, 1'b1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(OP_SEARCH,      0, 0, 1'b1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(OP_PEEK,        0, 1, 1'b1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(OP_REVERSE,     0, 0, 1'b1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(OP_SPARE_FIRST, -1, 255, 1'b1, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_PUSH, WORD_MIN, 0, 1'b1, ST_OK, 0, 0, 1));
        dir_rows.push_back(row(OP_PUSH, WORD_MAX, 0, 1'b1, ST_OK, 0, 0, 2));
        dir_rows.push_back(row(OP_PUSH, -1,       0, 1'b1, ST_OK, 0, 0, 3));
        dir_rows.push_back(row(OP_PUSH, 0,        0, 1'b1, ST_OK, 0, 0, 4));
        dir_rows.push_back(row(OP_PUSH, 1,        0, 1'b1, ST_OK, 0, 0, 5));
        dir_rows.push_back(row(OP_PUSH, 5,        0, 1'b1, ST_OK, 0, 0, 6));
        dir_rows.push_back(row(OP_PUSH, 5,        0, 1'b1, ST_OK, 0, 0, 7));
        dir_rows.push_back(row(OP_PUSH, 32'sh55aa_55aa, 0, 1'b1, ST_OK, 0, 0, 8));
        dir_rows.push_back(row(OP_PUSH, 7,        0, 1'b1, ST_FULL, 0, 0, 8));
        dir_rows.push_back(row(OP_PEEK, 0, 0,   1'b1, ST_BAD_POS, 0, 0, 8));
        dir_rows.push_back(row(OP_PEEK, 0, 9,   1'b1, ST_BAD_POS, 0, 0, 8));
        dir_rows.push_back(row(OP_PEEK, 0, 255, 1'b1, ST_BAD_POS, 0, 0, 8));
        dir_rows.push_back(row(OP_PEEK, 0, 8,   1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_PEEK, 0, 1,   1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_SEARCH, 5,  0, 1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_SEARCH, 42, 0, 1'b1, ST_NOT_FOUND, 0, 0, 8));
        dir_rows.push_back(row(OP_REVERSE, 0, 0, 1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_SEARCH, WORD_MIN, 0, 1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_POP, 0, 0, 1'b0, ST_OK, 0, 0, 0));
        dir_rows.push_back(row(OP_SPARE_LAST, 0, 0, 1'b0, ST_OK, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            d    = dir_rows[k];
            pred = apply_stack_op(d.op, d.value, d.position);
            awaited_results.push_back(d.typed ? d.want : pred);
            send_request(d.op, d.value, d.position);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= 250 && n < 350) ? 0 : 10;
            if (n == 120)
                hold_off_pending = 1'b1;
            // alternate filling, draining and mixed phases to reach full and empty often
            case ((n / 40) % 3)
                0:       begin push_pct = 45; pop_pct = 15; end
                1:       begin push_pct = 15; pop_pct = 45; end
                default: begin push_pct = 30; pop_pct = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll < push_pct)
                op = OP_PUSH;
            else if (roll < push_pct + pop_pct)
                op = OP_POP;
            else if (roll < 75)
                op = OP_SEARCH;
            else if (roll < 90)
                op = OP_PEEK;
            else if (roll < 97)
                op = OP_REVERSE;
            else
                op = OP_SPARE_FIRST + t_op'($urandom_range(2));

            case ($urandom_range(3))
                0:       val = t_word'($urandom_range(8)) - 4;
                1:       val = $urandom_range(1) ? WORD_MIN : WORD_MAX;
                default: val = t_word'($urandom());
            endcase
            if (op == OP_SEARCH && stack_fill > 0 && $urandom_range(9) < 7)
                val = stack_mem[$urandom_range(stack_fill - 1)];

            case ($urandom_range(3))
                0:       pos = t_count'($urandom_range(255));
                1:       pos = t_count'(stack_fill + $urandom_range(1));
                default: pos = t_count'($urandom_range(stack_fill > 0 ? stack_fill : 1, 1));
            endcase

            awaited_results.push_back(apply_stack_op(op, val, pos));
            send_request(op, val, pos);
        end
        req_bus.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
